FILE: hw/rtl/lr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_pkg: shared types and constants of the line rasterizer
// Field widths, register indexes, item kinds and the records passed between
// the command front end, the Bresenham stepper and the address pipeline.
// ----------------------------------------------------------------------------
package lr_pkg;

   // field widths
   localparam int COORD_W  = 12;
   localparam int DIM_W    = 13;
   localparam int BPP_W    = 3;
   localparam int COLOR_W  = 32;
   localparam int ADDR_W   = 26;
   localparam int ERR_W    = 15;
   localparam int TWICE_W  = 14;
   localparam int PROD_W   = COORD_W + DIM_W;
   localparam int CSR_IDX_W = 2;

   // stream payload widths
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 88;

   // largest bytes per pixel
   localparam logic [BPP_W-1:0] BPP_MAX = 3'd4;

   // item kinds
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_PIXEL = 2'd2;

   // decoded command, front end to stepper
   typedef struct packed {
      logic                      is_step;
      logic                      bad;
      logic [COORD_W-1:0]        x0;
      logic [COORD_W-1:0]        y0;
      logic [TWICE_W-1:0]        twice_dx;
      logic [TWICE_W-1:0]        twice_dy;
      logic signed [ERR_W-1:0]   err_init;
      logic [COORD_W-1:0]        major;
      logic                      x_neg;
      logic                      y_neg;
      logic                      x_major;
      logic [COLOR_W-1:0]        color;
   } lr_cmd_type;

   // one pixel, stepper to address pipeline
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COLOR_W-1:0] color;
      logic               last;
      logic               bad;
   } lr_pix_type;

   // effective frame settings for the address pipeline
   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [BPP_W-1:0] bpp;
   } lr_cfg_type;

endpackage

FILE: hw/rtl/lr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_front: command front end
// Holds the frame registers, checks endpoints, works out the line setup and
// queues decoded commands for the stepper.
// ----------------------------------------------------------------------------
module lr_front #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lr_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                              req_tuser,
   input  logic                              csr_we,
   input  logic [lr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lr_pkg::DIM_W-1:0]          csr_wdata,
   output lr_pkg::lr_cfg_type                cfg_o,
   output logic                              cmd_valid_o,
   output lr_pkg::lr_cmd_type                cmd_o,
   input  logic                              cmd_take_i
);

   localparam int CW     = lr_pkg::COORD_W;
   localparam int DW     = lr_pkg::DIM_W;
   localparam int BW     = lr_pkg::BPP_W;
   localparam int TW     = lr_pkg::TWICE_W;
   localparam int EW     = lr_pkg::ERR_W;
   localparam int QDEPTH = 2;
   localparam int QAW    = $clog2(QDEPTH);
   localparam int QCW    = QAW + 1;

   logic [DW-1:0] width_ff, width_in;
   logic [DW-1:0] height_ff, height_in;
   logic [BW-1:0] bpp_ff, bpp_in;
   logic [DW-1:0] eff_width;
   logic [DW-1:0] eff_height;

   logic [CW-1:0] x0, y0, x1, y1;
   logic [CW-1:0] dx, dy;
   logic          x_neg, y_neg, x_major;
   logic [TW-1:0] twice_dx, twice_dy;
   lr_pkg::lr_cmd_type cmd_new;

   lr_pkg::lr_cmd_type q_mem [QDEPTH];
   logic [QAW-1:0] wr_ff, wr_in;
   logic [QAW-1:0] rd_ff, rd_in;
   logic [QCW-1:0] cnt_ff, cnt_in;
   logic           push, pop;

   // frame registers
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      bpp_in    = bpp_ff;
      if (csr_we) begin
         case (csr_index)
            lr_pkg::CSR_FRAME_WIDTH:     width_in  = csr_wdata;
            lr_pkg::CSR_FRAME_HEIGHT:    height_in = csr_wdata;
            lr_pkg::CSR_BYTES_PER_PIXEL: bpp_in    = csr_wdata[BW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DW'(640);
         height_ff <= DW'(480);
         bpp_ff    <= lr_pkg::BPP_MAX;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         bpp_ff    <= bpp_in;
      end
   end

   // clamp frame size and pixel size
   assign eff_width  = (32'(width_ff) > 32'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : width_ff;
   assign eff_height = (32'(height_ff) > 32'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : height_ff;
   assign cfg_o.width = eff_width;
   assign cfg_o.bpp   = (bpp_ff > lr_pkg::BPP_MAX) ? lr_pkg::BPP_MAX : bpp_ff;

   // unpack the beat and work out the line setup
   assign x0 = req_tdata[CW-1:0];
   assign y0 = req_tdata[2*CW-1:CW];
   assign x1 = req_tdata[3*CW-1:2*CW];
   assign y1 = req_tdata[4*CW-1:3*CW];

   assign x_neg    = x1 < x0;
   assign y_neg    = y1 < y0;
   assign dx       = x_neg ? (x0 - x1) : (x1 - x0);
   assign dy       = y_neg ? (y0 - y1) : (y1 - y0);
   assign x_major  = dx > dy;
   assign twice_dx = {1'b0, dx, 1'b0};
   assign twice_dy = {1'b0, dy, 1'b0};

   always_comb begin
      cmd_new.is_step  = (req_tuser == lr_pkg::KIND_STEP);
      cmd_new.bad      = ({1'b0, x0} >= eff_width) || ({1'b0, x1} >= eff_width) ||
                         ({1'b0, y0} >= eff_height) || ({1'b0, y1} >= eff_height);
      cmd_new.x0       = x0;
      cmd_new.y0       = y0;
      cmd_new.twice_dx = twice_dx;
      cmd_new.twice_dy = twice_dy;
      cmd_new.x_neg    = x_neg;
      cmd_new.y_neg    = y_neg;
      cmd_new.x_major  = x_major;
      cmd_new.color    = req_tdata[4*CW+lr_pkg::COLOR_W-1:4*CW];
      if (x_major) begin
         cmd_new.err_init = $signed({1'b0, twice_dy}) - $signed(EW'(dx));
         cmd_new.major    = dx;
      end else begin
         cmd_new.err_init = $signed({1'b0, twice_dx}) - $signed(EW'(dy));
         cmd_new.major    = dy;
      end
   end

   // command queue
   assign req_tready  = (cnt_ff != QCW'(QDEPTH));
   assign push        = req_tvalid && req_tready;
   assign cmd_valid_o = (cnt_ff != '0);
   assign pop         = cmd_valid_o && cmd_take_i;
   assign cmd_o       = q_mem[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ff] <= cmd_new;
      end
   end

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == QAW'(QDEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == QAW'(QDEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: hw/rtl/lr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_back: Bresenham stepper
// Keeps the line state, emits at most one pixel per command and advances the
// current point along the major axis.
// ----------------------------------------------------------------------------
module lr_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid_i,
   input  lr_pkg::lr_cmd_type   cmd_i,
   output logic                 cmd_take_o,
   input  logic                 go_i,
   output logic                 pix_valid_o,
   output lr_pkg::lr_pix_type   pix_o
);

   localparam int CW = lr_pkg::COORD_W;
   localparam int TW = lr_pkg::TWICE_W;
   localparam int EW = lr_pkg::ERR_W;

   logic                    active_ff, active_in;
   logic [CW-1:0]           cur_x_ff, cur_x_in;
   logic [CW-1:0]           cur_y_ff, cur_y_in;
   logic signed [EW-1:0]    err_ff, err_in;
   logic [TW-1:0]           tdx_ff, tdx_in;
   logic [TW-1:0]           tdy_ff, tdy_in;
   logic                    xneg_ff, xneg_in;
   logic                    yneg_ff, yneg_in;
   logic                    xmaj_ff, xmaj_in;
   logic [CW-1:0]           left_ff, left_in;
   logic [lr_pkg::COLOR_W-1:0] color_ff, color_in;

   logic                    pix_vld_ff;
   lr_pkg::lr_pix_type      pix_ff, pix_in;
   logic                    emit;
   logic                    do_adv;
   logic                    fire;
   logic                    step_minor;
   logic [TW-1:0]           tmaj, tmin;
   logic signed [EW:0]      err_w;

   assign fire       = cmd_valid_i && go_i;
   assign cmd_take_o = fire;

   // next line state and emitted pixel
   always_comb begin
      active_in = active_ff;
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      err_in    = err_ff;
      tdx_in    = tdx_ff;
      tdy_in    = tdy_ff;
      xneg_in   = xneg_ff;
      yneg_in   = yneg_ff;
      xmaj_in   = xmaj_ff;
      left_in   = left_ff;
      color_in  = color_ff;
      emit      = 1'b0;
      do_adv    = 1'b0;
      pix_in    = '0;
      tmaj      = '0;
      tmin      = '0;
      step_minor = 1'b0;
      err_w     = '0;

      if (fire) begin
         if (cmd_i.is_step) begin
            // next pixel of the running line
            if (active_ff) begin
               left_in      = left_ff - 1'b1;
               emit         = 1'b1;
               pix_in.x     = cur_x_ff;
               pix_in.y     = cur_y_ff;
               pix_in.color = color_ff;
               pix_in.last  = (left_in == '0);
               active_in    = (left_in != '0);
               do_adv       = (left_in != '0);
            end
         end else if (cmd_i.bad) begin
            // endpoint outside the frame
            active_in   = 1'b0;
            emit        = 1'b1;
            pix_in.last = 1'b1;
            pix_in.bad  = 1'b1;
         end else begin
            // load a new line and emit its first point
            cur_x_in     = cmd_i.x0;
            cur_y_in     = cmd_i.y0;
            err_in       = cmd_i.err_init;
            tdx_in       = cmd_i.twice_dx;
            tdy_in       = cmd_i.twice_dy;
            xneg_in      = cmd_i.x_neg;
            yneg_in      = cmd_i.y_neg;
            xmaj_in      = cmd_i.x_major;
            left_in      = cmd_i.major;
            color_in     = cmd_i.color;
            emit         = 1'b1;
            pix_in.x     = cmd_i.x0;
            pix_in.y     = cmd_i.y0;
            pix_in.color = cmd_i.color;
            pix_in.last  = (cmd_i.major == '0);
            active_in    = (cmd_i.major != '0);
            do_adv       = (cmd_i.major != '0);
         end
      end

      // one Bresenham step on the updated state
      if (do_adv) begin
         tmaj       = xmaj_in ? tdx_in : tdy_in;
         tmin       = xmaj_in ? tdy_in : tdx_in;
         step_minor = !err_in[EW-1];
         err_w      = $signed({err_in[EW-1], err_in}) + $signed({2'b00, tmin})
                      - (step_minor ? $signed({2'b00, tmaj}) : $signed((EW+1)'(0)));
         err_in     = err_w[EW-1:0];
         if (xmaj_in || step_minor) begin
            cur_x_in = xneg_in ? cur_x_in - 1'b1 : cur_x_in + 1'b1;
         end
         if (!xmaj_in || step_minor) begin
            cur_y_in = yneg_in ? cur_y_in - 1'b1 : cur_y_in + 1'b1;
         end
      end
   end

   // line state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cur_x_ff  <= '0;
         cur_y_ff  <= '0;
         err_ff    <= '0;
         tdx_ff    <= '0;
         tdy_ff    <= '0;
         xneg_ff   <= 1'b0;
         yneg_ff   <= 1'b0;
         xmaj_ff   <= 1'b0;
         left_ff   <= '0;
         color_ff  <= '0;
      end else begin
         active_ff <= active_in;
         cur_x_ff  <= cur_x_in;
         cur_y_ff  <= cur_y_in;
         err_ff    <= err_in;
         tdx_ff    <= tdx_in;
         tdy_ff    <= tdy_in;
         xneg_ff   <= xneg_in;
         yneg_ff   <= yneg_in;
         xmaj_ff   <= xmaj_in;
         left_ff   <= left_in;
         color_ff  <= color_in;
      end
   end

   // pixel register, moves with the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         pix_vld_ff <= 1'b0;
      end else if (go_i) begin
         pix_vld_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (go_i) begin
         pix_ff <= pix_in;
      end
   end

   assign pix_valid_o = pix_vld_ff;
   assign pix_o       = pix_ff;

   // a running line always has pixels to come
   a_active_left: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (left_ff != '0))
      else $error("active line with no pixels left");

   // an error beat always closes the line
   a_bad_last: assert property (@(posedge clock) disable iff (reset)
      (pix_vld_ff && pix_ff.bad) |-> (pix_ff.last && !active_ff))
      else $error("error pixel without last or with line still running");

   // a step with no line running gives no pixel
   a_idle_step: assert property (@(posedge clock) disable iff (reset)
      (fire && cmd_i.is_step && !active_ff) |=> !pix_vld_ff)
      else $error("pixel emitted for a step while idle");

endmodule

FILE: hw/rtl/lr_addr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_addr: byte address pipeline
// Three stages: row times width, plus column, times bytes per pixel, the
// last one being the result register.
// ----------------------------------------------------------------------------
module lr_addr (
   input  logic                          clock,
   input  logic                          reset,
   input  lr_pkg::lr_cfg_type            cfg_i,
   input  logic                          pix_valid_i,
   input  lr_pkg::lr_pix_type            pix_i,
   output logic                          go_o,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output lr_pkg::lr_pix_type            rsp_pix_o,
   output logic [lr_pkg::ADDR_W-1:0]     rsp_addr_o
);

   localparam int PW = lr_pkg::PROD_W;
   localparam int AW = lr_pkg::ADDR_W;

   logic               s1_vld_ff;
   lr_pkg::lr_pix_type s1_pix_ff;
   logic [PW-1:0]      s1_prod_ff;
   logic               s2_vld_ff;
   lr_pkg::lr_pix_type s2_pix_ff;
   logic [PW-1:0]      s2_sum_ff;
   logic               out_vld_ff;
   lr_pkg::lr_pix_type out_pix_ff;
   logic [AW-1:0]      out_addr_ff;
   logic [PW+1:0]      scaled;

   // whole pipeline moves unless the result beat is held
   assign go_o = !out_vld_ff || rsp_tready;

   // scale by bytes per pixel
   always_comb begin
      case (cfg_i.bpp)
         3'd0:    scaled = '0;
         3'd1:    scaled = {2'b00, s2_sum_ff};
         3'd2:    scaled = {1'b0, s2_sum_ff, 1'b0};
         3'd3:    scaled = {2'b00, s2_sum_ff} + {1'b0, s2_sum_ff, 1'b0};
         3'd4:    scaled = {s2_sum_ff, 2'b00};
         default: scaled = '0;
      endcase
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (go_o) begin
         s1_vld_ff  <= pix_valid_i;
         s2_vld_ff  <= s1_vld_ff;
         out_vld_ff <= s2_vld_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (go_o) begin
         s1_pix_ff   <= pix_i;
         s1_prod_ff  <= PW'(pix_i.y) * PW'(cfg_i.width);
         s2_pix_ff   <= s1_pix_ff;
         s2_sum_ff   <= s1_prod_ff + PW'(s1_pix_ff.x);
         out_pix_ff  <= s2_pix_ff;
         out_addr_ff <= scaled[AW-1:0];
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_pix_o  = out_pix_ff;
   assign rsp_addr_o = out_addr_ff;

endmodule

FILE: hw/rtl/line_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_rasterizer: Bresenham line pixel generator
// A start beat checks and sets up a line and gives its first pixel or an error
// beat; each step beat on a running line gives its next pixel and byte address.
// ----------------------------------------------------------------------------
//  group  dir  beat contents
//  req_   in   start/step command, two endpoints and colour
//  rsp_   out  pixel x, y, byte address, colour, last, error flag
//  csr_   in   frame width, frame height, bytes per pixel writes
//
//  one pixel per clock while no rsp_ beat is held; a result beat passes
//  the command queue, the stepper, two address stages and the result
//  register between its req_ beat and rsp_
//  the stepper's Bresenham update bounds the rate
//  reset clears the queue, the line state and the pipeline valid bits,
//  and loads 640 x 480 with four bytes per pixel
//  a held rsp_ beat stalls stepper and address stages; req_ keeps taking
//  beats until the command queue is full
// ----------------------------------------------------------------------------
module line_rasterizer #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   // start_x, start_y, end_x, end_y, color
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [lr_pkg::REQ_DATA_W-1:0]    req_tdata,
   // kind
   input  logic                             req_tuser,
   // pixel_x, pixel_y, byte_address, pixel_color, zero fill
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lr_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                             rsp_tlast,
   // bad_endpoints
   output logic                             rsp_tuser,
   input  logic                             csr_we,
   input  logic [lr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lr_pkg::DIM_W-1:0]         csr_wdata
);

   localparam int PAD_W = lr_pkg::RSP_DATA_W - 2 * lr_pkg::COORD_W
                          - lr_pkg::ADDR_W - lr_pkg::COLOR_W;

   lr_pkg::lr_cfg_type          cfg;
   lr_pkg::lr_cmd_type          cmd;
   logic                        cmd_valid;
   logic                        cmd_take;
   logic                        go;
   logic                        pix_valid;
   lr_pkg::lr_pix_type          pix;
   lr_pkg::lr_pix_type          rsp_pix;
   logic [lr_pkg::ADDR_W-1:0]   rsp_addr;

   // command front end
   lr_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cfg_o       (cfg),
      .cmd_valid_o (cmd_valid),
      .cmd_o       (cmd),
      .cmd_take_i  (cmd_take)
   );

   // stepper
   lr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid_i (cmd_valid),
      .cmd_i       (cmd),
      .cmd_take_o  (cmd_take),
      .go_i        (go),
      .pix_valid_o (pix_valid),
      .pix_o       (pix)
   );

   // address pipeline and result register
   lr_addr u_addr (
      .clock       (clock),
      .reset       (reset),
      .cfg_i       (cfg),
      .pix_valid_i (pix_valid),
      .pix_i       (pix),
      .go_o        (go),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_pix_o   (rsp_pix),
      .rsp_addr_o  (rsp_addr)
   );

   // result beat packing
   assign rsp_tdata = {PAD_W'(0), rsp_pix.color, rsp_addr, rsp_pix.y, rsp_pix.x};
   assign rsp_tlast = rsp_pix.last;
   assign rsp_tuser = rsp_pix.bad;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the line rasterizer
// Drives start and step beats into req_, predicts each pixel with a local
// Bresenham stepper and checks every rsp_ beat field by field. Runs directed
// corner lines, then random phases over several frame settings with sender idle,
// receiver stall and long receiver hold-off patterns.
// ----------------------------------------------------------------------------
module tb;

   localparam int FRAME_MAX_W  = 4096;
   localparam int FRAME_MAX_H  = 4096;
   localparam int PIPE_LATENCY = 5;
   // longest quiet stretch of a good run is the hold-off plus a config pause
   localparam int HOLD_CYCLES  = 400;
   localparam int STALL_LIMIT  = 3000;
   localparam int PRINT_LIMIT  = 30;
   localparam int FILL_W       = lr_pkg::RSP_DATA_W - 2 * lr_pkg::COORD_W
                                 - lr_pkg::ADDR_W - lr_pkg::COLOR_W;
   // index with no register behind it
   localparam logic [lr_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // one req_ beat as kind over tdata
   typedef struct packed {
      logic                       kind;
      logic [lr_pkg::COLOR_W-1:0] color;
      logic [lr_pkg::COORD_W-1:0] ey;
      logic [lr_pkg::COORD_W-1:0] ex;
      logic [lr_pkg::COORD_W-1:0] sy;
      logic [lr_pkg::COORD_W-1:0] sx;
   } draw_cmd_type;

   localparam int CMD_W = $bits(draw_cmd_type);

   // one rsp_ beat as tuser, tlast over tdata
   typedef struct packed {
      logic                       bad;
      logic                       last;
      logic [FILL_W-1:0]          fill;
      logic [lr_pkg::COLOR_W-1:0] color;
      logic [lr_pkg::ADDR_W-1:0]  addr;
      logic [lr_pkg::COORD_W-1:0] y;
      logic [lr_pkg::COORD_W-1:0] x;
   } pixel_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [lr_pkg::REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                            req_tuser  = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [lr_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                            rsp_tlast;
   logic                            rsp_tuser;
   logic                            csr_we     = 1'b0;
   logic [lr_pkg::CSR_IDX_W-1:0]    csr_index  = '0;
   logic [lr_pkg::DIM_W-1:0]        csr_wdata  = '0;

   // shadow of the frame registers
   logic [lr_pkg::DIM_W-1:0]        cfg_width  = 13'd640;
   logic [lr_pkg::DIM_W-1:0]        cfg_height = 13'd480;
   logic [lr_pkg::BPP_W-1:0]        cfg_bpp    = 3'd4;

   // shadow of the line stepper
   logic                            ln_active  = 1'b0;
   logic [lr_pkg::COORD_W-1:0]      ln_x       = '0;
   logic [lr_pkg::COORD_W-1:0]      ln_y       = '0;
   int                              ln_err     = 0;
   int                              ln_2dx     = 0;
   int                              ln_2dy     = 0;
   logic                            ln_xneg    = 1'b0;
   logic                            ln_yneg    = 1'b0;
   logic                            ln_xmajor  = 1'b0;
   logic [lr_pkg::COORD_W-1:0]      ln_left    = '0;
   logic [lr_pkg::COLOR_W-1:0]      ln_color   = '0;

   draw_cmd_type            pending_cmds[$];
   pixel_type               expected_pixels[$];
   logic                    req_fired      = 1'b0;
   int                      cmds_queued    = 0;
   int                      cmds_accepted  = 0;
   int                      pixels_checked = 0;
   int                      rejects_seen   = 0;
   int                      frame_settings = 0;
   int                      error_count    = 0;
   int                      idle_cycles    = 0;
   int                      send_idle_pct  = 0;
   int                      recv_stall_pct = 0;
   int                      hold_requests  = 0;
   int                      hold_served    = 0;
   int                      hold_left      = 0;
   int                      gen_w          = 640;
   int                      gen_h          = 480;

   line_rasterizer #(
      .MAX_WIDTH  (FRAME_MAX_W),
      .MAX_HEIGHT (FRAME_MAX_H)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   // pixel record with the frame address of the current settings
   function automatic pixel_type pixel_at(logic [lr_pkg::COORD_W-1:0] x,
                                          logic [lr_pkg::COORD_W-1:0] y,
                                          logic [lr_pkg::COLOR_W-1:0] color,
                                          logic last, logic bad);
      pixel_type p;
      longint unsigned w;
      longint unsigned bpp;
      longint unsigned addr;
      w    = (cfg_width > FRAME_MAX_W) ? FRAME_MAX_W : cfg_width;
      bpp  = (cfg_bpp > lr_pkg::BPP_MAX) ? lr_pkg::BPP_MAX : cfg_bpp;
      addr = (longint'(y) * w + x) * bpp;
      p.bad   = bad;
      p.last  = last;
      p.fill  = '0;
      p.x     = bad ? '0 : x;
      p.y     = bad ? '0 : y;
      p.color = bad ? '0 : color;
      p.addr  = bad ? '0 : addr[lr_pkg::ADDR_W-1:0];
      return p;
   endfunction

   // one Bresenham move along the major axis
   function automatic void advance_line();
      if (ln_xmajor) begin
         if (ln_err >= 0) begin
            ln_err -= ln_2dx;
            ln_y = ln_yneg ? ln_y - 1'b1 : ln_y + 1'b1;
         end
         ln_err += ln_2dy;
         ln_x = ln_xneg ? ln_x - 1'b1 : ln_x + 1'b1;
      end else begin
         if (ln_err >= 0) begin
            ln_err -= ln_2dy;
            ln_x = ln_xneg ? ln_x - 1'b1 : ln_x + 1'b1;
         end
         ln_err += ln_2dx;
         ln_y = ln_yneg ? ln_y - 1'b1 : ln_y + 1'b1;
      end
   endfunction

   // pixel caused by one accepted beat; returns 0 when none is due
   function automatic bit rasterize(input draw_cmd_type c, output pixel_type p);
      int w;
      int h;
      int dx;
      int dy;
      int major;
      w = (cfg_width > FRAME_MAX_W) ? FRAME_MAX_W : cfg_width;
      h = (cfg_height > FRAME_MAX_H) ? FRAME_MAX_H : cfg_height;
      if (c.kind == lr_pkg::KIND_START) begin
         // endpoint outside the frame: error beat, stepper idle
         if (c.sx >= w || c.ex >= w || c.sy >= h || c.ey >= h) begin
            ln_active = 1'b0;
            p = pixel_at('0, '0, '0, 1'b1, 1'b1);
            return 1'b1;
         end
         ln_xneg   = c.ex < c.sx;
         ln_yneg   = c.ey < c.sy;
         dx        = ln_xneg ? c.sx - c.ex : c.ex - c.sx;
         dy        = ln_yneg ? c.sy - c.ey : c.ey - c.sy;
         ln_2dx    = 2 * dx;
         ln_2dy    = 2 * dy;
         // on a tie y is the major axis
         ln_xmajor = dx > dy;
         ln_err    = ln_xmajor ? 2 * dy - dx : 2 * dx - dy;
         major     = ln_xmajor ? dx : dy;
         ln_x      = c.sx;
         ln_y      = c.sy;
         ln_color  = c.color;
         ln_left   = major[lr_pkg::COORD_W-1:0];
         p = pixel_at(ln_x, ln_y, ln_color, major == 0, 1'b0);
         ln_active = major != 0;
         if (ln_active)
            advance_line();
         return 1'b1;
      end
      if (!ln_active)
         return 1'b0;
      ln_left = ln_left - 1'b1;
      p = pixel_at(ln_x, ln_y, ln_color, ln_left == 0, 1'b0);
      if (ln_left == 0)
         ln_active = 1'b0;
      else
         advance_line();
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input longint unsigned want,
                                  input longint unsigned got);
      if (error_count < PRINT_LIMIT)
         $display("%0t ns: %s expected 0x%0h got 0x%0h", $time, what, want, got);
      error_count++;
   endtask

   // sample both handshakes and the register port, predict and compare
   always @(posedge clock) begin : scoreboard
      pixel_type got;
      pixel_type want;
      pixel_type pix;
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_tvalid && req_tready;
         if (csr_we) begin
            case (csr_index)
               lr_pkg::CSR_FRAME_WIDTH:     cfg_width  = csr_wdata;
               lr_pkg::CSR_FRAME_HEIGHT:    cfg_height = csr_wdata;
               lr_pkg::CSR_BYTES_PER_PIXEL: cfg_bpp    = csr_wdata[lr_pkg::BPP_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            cmds_accepted++;
            if (rasterize(draw_cmd_type'({req_tuser, req_tdata}), pix))
               expected_pixels.push_back(pix);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = pixel_type'({rsp_tuser, rsp_tlast, rsp_tdata});
            pixels_checked++;
            if (got.bad === 1'b1)
               rejects_seen++;
            if (expected_pixels.size() == 0) begin
               report_mismatch("pixel with nothing pending, x", 0, got.x);
            end else begin
               want = expected_pixels.pop_front();
               if (got.x !== want.x)         report_mismatch("pixel_x", want.x, got.x);
               if (got.y !== want.y)         report_mismatch("pixel_y", want.y, got.y);
               if (got.addr !== want.addr)   report_mismatch("byte_address", want.addr, got.addr);
               if (got.color !== want.color) report_mismatch("pixel_color", want.color, got.color);
               if (got.last !== want.last)   report_mismatch("last_pixel", want.last, got.last);
               if (got.bad !== want.bad)     report_mismatch("bad_endpoints", want.bad, got.bad);
            end
         end
      end
   end

   // no beat on any port for too long ends the run
   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat for %0d cycles, %0d pixels pending",
                     idle_cycles, expected_pixels.size());
            $display("line_rasterizer: mismatch");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   // command beats from the pending queue, held until taken
   always @(negedge clock) begin : req_driver
      draw_cmd_type cmd;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            cmd = pending_cmds.pop_front();
            {req_tuser, req_tdata} <= cmd;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, counted here
   always @(negedge clock) begin : rsp_hold_off
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_requests != hold_served) begin
         hold_left   <= HOLD_CYCLES;
         hold_served <= hold_requests;
      end
   end

   // random receiver stalls
   always @(negedge clock) begin : rsp_driver
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
   end

   // ---------------------------------------------------------------- stimulus

   task automatic push_start(input int sx, input int sy, input int ex, input int ey,
                             input logic [lr_pkg::COLOR_W-1:0] color);
      draw_cmd_type c;
      c.kind  = lr_pkg::KIND_START;
      c.sx    = sx[lr_pkg::COORD_W-1:0];
      c.sy    = sy[lr_pkg::COORD_W-1:0];
      c.ex    = ex[lr_pkg::COORD_W-1:0];
      c.ey    = ey[lr_pkg::COORD_W-1:0];
      c.color = color;
      pending_cmds.push_back(c);
      cmds_queued++;
   endtask

   // step beat; the unused fields carry junk
   task automatic push_step();
      draw_cmd_type c;
      c = draw_cmd_type'(CMD_W'({$urandom, $urandom, $urandom}));
      c.kind = lr_pkg::KIND_STEP;
      pending_cmds.push_back(c);
      cmds_queued++;
   endtask

   task automatic push_line(input int sx, input int sy, input int ex, input int ey,
                            input logic [lr_pkg::COLOR_W-1:0] color, input int steps);
      push_start(sx, sy, ex, ey, color);
      repeat (steps) push_step();
   endtask

   function automatic int clamp_coord(int v, int lim);
      return (v < 0) ? 0 : ((v >= lim) ? lim - 1 : v);
   endfunction

   // all beats taken and all pixels back, then room for trailing idle steps
   task automatic wait_drain();
      while (cmds_accepted != cmds_queued || expected_pixels.size() != 0)
         @(negedge clock);
      repeat (PIPE_LATENCY * 3) @(negedge clock);
   endtask

   // one write per cycle, enable held across the burst
   task automatic write_frame(input int w, input int h, input int bpp);
      logic [31:0] junk;
      junk      = $urandom;
      csr_we    <= 1'b1;
      csr_index <= lr_pkg::CSR_FRAME_WIDTH;
      csr_wdata <= w[lr_pkg::DIM_W-1:0];
      @(negedge clock);
      csr_index <= lr_pkg::CSR_FRAME_HEIGHT;
      csr_wdata <= h[lr_pkg::DIM_W-1:0];
      @(negedge clock);
      csr_index <= lr_pkg::CSR_BYTES_PER_PIXEL;
      csr_wdata <= bpp[lr_pkg::DIM_W-1:0];
      @(negedge clock);
      csr_index <= CSR_UNUSED;
      csr_wdata <= junk[lr_pkg::DIM_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      gen_w = (w[lr_pkg::DIM_W-1:0] > FRAME_MAX_W) ? FRAME_MAX_W : w[lr_pkg::DIM_W-1:0];
      gen_h = (h[lr_pkg::DIM_W-1:0] > FRAME_MAX_H) ? FRAME_MAX_H : h[lr_pkg::DIM_W-1:0];
      frame_settings++;
   endtask

   // mostly whole lines in frame, some cut short or overrun, plus noise
   task automatic random_lines(input int n_items);
      int done;
      int r;
      int len;
      int sx;
      int sy;
      int ex;
      int ey;
      int major;
      int steps;
      done = 0;
      while (done < n_items) begin
         r = $urandom_range(99);
         if (r < 70 && gen_w > 0 && gen_h > 0) begin
            len = ($urandom_range(24) == 0) ? $urandom_range(160) : $urandom_range(12);
            sx  = $urandom_range(gen_w - 1);
            sy  = $urandom_range(gen_h - 1);
            ex  = clamp_coord(sx + int'($urandom_range(2 * len)) - len, gen_w);
            ey  = clamp_coord(sy + int'($urandom_range(2 * len)) - len, gen_h);
            major = (ex > sx ? ex - sx : sx - ex);
            if ((ey > sy ? ey - sy : sy - ey) > major)
               major = ey > sy ? ey - sy : sy - ey;
            case ($urandom_range(9))
               0:       steps = (major == 0) ? 0 : $urandom_range(major - 1);
               1:       steps = major + 1 + $urandom_range(2);
               default: steps = major;
            endcase
            push_line(sx, sy, ex, ey, $urandom, steps);
            done += 1 + ((steps < major) ? steps : major);
         end else if (r < 90) begin
            // full-range endpoints, mostly rejected on smaller frames
            push_start($urandom_range(4095), $urandom_range(4095),
                       $urandom_range(4095), $urandom_range(4095), $urandom);
            done++;
         end else begin
            push_step();
         end
      end
   endtask

   task automatic run_phase(input int w, input int h, input int bpp,
                            input int send_pct, input int recv_pct, input int n_items);
      wait_drain();
      write_frame(w, h, bpp);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      random_lines(n_items);
   endtask

   initial begin : stimulus
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed lines on the reset frame of 640 x 480, four bytes per pixel
      push_line(0, 0, 0, 0, 32'h0000_0000, 0);          // single point at origin
      push_line(639, 479, 636, 477, 32'hFFFF_FFFF, 3);  // far corner, both axes down
      push_line(10, 10, 13, 13, 32'h1234_5678, 3);      // diagonal tie
      push_line(100, 20, 98, 27, 32'h89AB_CDEF, 7);     // steep, x going down
      push_start(640, 0, 0, 0, 32'hDEAD_BEEF);          // start column on the edge
      push_start(0, 0, 4095, 4095, 32'h5555_AAAA);      // end far outside
      push_start(3, 2, 1, 480, 32'hAAAA_5555);          // end row on the edge
      push_step();                                      // step with no line
      push_line(5, 5, 10, 6, 32'h0F0F_0F0F, 2);         // cut short by the next start
      push_line(200, 100, 201, 100, 32'hF0F0_F0F0, 1);

      // largest frame, smallest pixel, and a long receiver hold-off
      wait_drain();
      write_frame(FRAME_MAX_W, FRAME_MAX_H, 1);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_requests++;
      push_line(0, 0, 80, 30, $urandom, 80);
      random_lines(150);

      run_phase(8191, 8191, 7, 87, 0, 130);   // saturated settings
      run_phase(1, 1, 0, 0, 87, 40);          // single-pixel frame, zero bytes
      run_phase(0, 5000, 2, 19, 19, 30);      // zero width rejects everything
      run_phase($urandom_range(4096, 1), $urandom_range(4096, 1), $urandom_range(4, 1),
                0, 0, 150);
      run_phase($urandom_range(4096, 1), $urandom_range(4096, 1), $urandom_range(4, 1),
                87, 0, 150);
      run_phase($urandom_range(4096, 1), $urandom_range(4096, 1), $urandom_range(4, 1),
                0, 87, 150);
      run_phase($urandom_range(8191, 1), $urandom_range(8191, 1), $urandom_range(7),
                19, 19, 150);

      wait_drain();
      repeat (PIPE_LATENCY * 4) @(negedge clock);
      $display("covered %0d command beats and %0d pixels over %0d frame settings",
               cmds_accepted, pixels_checked, frame_settings);
      $display("%0d endpoint rejections, %0d field mismatches", rejects_seen, error_count);
      if (error_count == 0 && expected_pixels.size() == 0)
         $display("line_rasterizer: match");
      else
         $display("line_rasterizer: mismatch");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/lr_pkg.sv
hw/rtl/lr_front.sv
hw/rtl/lr_back.sv
hw/rtl/lr_addr.sv
hw/rtl/line_rasterizer.sv
verif/tb.sv
